FILE: rtl/core/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// Types, constants and trig lookup shared by the vertex rotate/project pipeline.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int COORD_W    = 27;
  localparam int TRIG_W     = 16;
  localparam int PROD_W     = COORD_W + TRIG_W;
  localparam int RND_W      = 48;
  localparam int NUM_STAGES = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ISO_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM       = 3'd6;

  localparam longint PI_Q30 = 64'sd3373259426;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_depth;
  } out_item_t;

  function automatic logic [90:0][14:0] build_qsin();
    logic [90:0][14:0] q;
    longint x, x2, term, sum;
    int d;
    q = '0;
    for (d = 0; d <= 90; d++) begin
      x    = longint'(d) * PI_Q30 / 180;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >>> 30) / 64'sd6;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 64'sd20;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 64'sd42;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 64'sd72;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 64'sd110;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 64'sd156;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 64'sd210;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 64'sd272;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 64'sd342;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 64'sd420;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 64'sd506;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 64'sd600;
      sum  = sum + term;
      if (sum < 0) begin
        sum = 0;
      end
      q[d] = 15'((sum + 32768) >>> 16);
    end
    return q;
  endfunction

  localparam logic [90:0][14:0] QSIN = build_qsin();

  // Quarter-wave lookup; argument 0..719.
  function automatic trig_t sin_deg(input logic [9:0] d);
    logic [9:0]  r;
    logic [6:0]  idx;
    logic        neg;
    trig_t       mag;
    r = (d >= 10'd360) ? d - 10'd360 : d;
    if (r <= 10'd90) begin
      idx = r[6:0];
      neg = 1'b0;
    end else if (r <= 10'd180) begin
      idx = 7'(10'd180 - r);
      neg = 1'b0;
    end else if (r <= 10'd270) begin
      idx = 7'(r - 10'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(10'd360 - r);
      neg = 1'b1;
    end
    mag = signed'({1'b0, QSIN[idx]});
    return neg ? -mag : mag;
  endfunction

  function automatic trig_t cos_deg(input logic [8:0] a);
    logic [8:0] r;
    r = (a >= 9'd360) ? a - 9'd360 : a;
    return sin_deg(10'(r) + 10'd90);
  endfunction

  function automatic coord_t rnd14(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] t;
    t = v + RND_W'(8192);
    return COORD_W'(t >>> 14);
  endfunction

endpackage

FILE: rtl/core/vertex_rotate_project_top.sv
// ----------------------------------------------------------------------------
// vertex_rotate_project_top
// Euler rotation (X, Y, Z) and isometric projection of one vertex per beat.
// ----------------------------------------------------------------------------
// A vertex passes 13 register stages between its input beat and its result:
// one capture stage, two per rotation (multiply, then sum and
// round), three for the isometric unit and three for offset, zoom and
// centring. Every stage advances independently, so one vertex is accepted per
// cycle whenever the output is taken, and empty stages fill while the output
// is stalled.
// Sine and cosine of the angles come from a 91-entry quarter-wave table and
// are registered behind the angle registers, so they follow an angle write.
module vertex_rotate_project_top
  import vrp_pkg::*;
#(
  parameter int WINDOW_WIDTH  = 1920,
  parameter int WINDOW_HEIGHT = 1080
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [NUM_STAGES-1:0] en;

  logic [8:0]         angle_x_r, angle_y_r, angle_z_r;
  logic               iso_enable_r;
  logic signed [15:0] offset_x_r, offset_y_r;
  logic [15:0]        zoom_r;

  trig_t sin_x_r, cos_x_r, sin_y_r, cos_y_r, sin_z_r, cos_z_r;
  trig_t sin_x_nxt, cos_x_nxt, sin_y_nxt, cos_y_nxt, sin_z_nxt, cos_z_nxt;

  vec_t in_r, in_nxt;
  vec_t v_rx, v_ry, v_rz, v_iso;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_x_r    <= '0;
      angle_y_r    <= '0;
      angle_z_r    <= '0;
      iso_enable_r <= 1'b1;
      offset_x_r   <= '0;
      offset_y_r   <= '0;
      zoom_r       <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ANGLE_X:    angle_x_r    <= cfg_wdata[8:0];
        CFG_ANGLE_Y:    angle_y_r    <= cfg_wdata[8:0];
        CFG_ANGLE_Z:    angle_z_r    <= cfg_wdata[8:0];
        CFG_ISO_ENABLE: iso_enable_r <= cfg_wdata[0];
        CFG_OFFSET_X:   offset_x_r   <= signed'(cfg_wdata);
        CFG_OFFSET_Y:   offset_y_r   <= signed'(cfg_wdata);
        CFG_ZOOM:       zoom_r       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sin_x_nxt = sin_deg({1'b0, angle_x_r});
    cos_x_nxt = cos_deg(angle_x_r);
    sin_y_nxt = sin_deg({1'b0, angle_y_r});
    cos_y_nxt = cos_deg(angle_y_r);
    sin_z_nxt = sin_deg({1'b0, angle_z_r});
    cos_z_nxt = cos_deg(angle_z_r);
    in_nxt.x  = COORD_W'(signed'({in_data.in_x, 8'h00}));
    in_nxt.y  = COORD_W'(signed'({in_data.in_y, 8'h00}));
    in_nxt.z  = COORD_W'(signed'({in_data.in_z, 8'h00}));
  end

  always_ff @(posedge clk) begin
    sin_x_r <= sin_x_nxt;
    cos_x_r <= cos_x_nxt;
    sin_y_r <= sin_y_nxt;
    cos_y_r <= cos_y_nxt;
    sin_z_r <= sin_z_nxt;
    cos_z_r <= cos_z_nxt;
    if (en[0]) begin
      in_r <= in_nxt;
    end
  end

  vrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .en        (en)
  );

  // about X: (y, z)
  vrp_rot u_rot_x (
    .clk   (clk),
    .en    (en[2:1]),
    .a_i   (in_r.y),
    .b_i   (in_r.z),
    .p_i   (in_r.x),
    .sin_i (sin_x_r),
    .cos_i (cos_x_r),
    .a_o   (v_rx.y),
    .b_o   (v_rx.z),
    .p_o   (v_rx.x)
  );

  // about Y: (z, x)
  vrp_rot u_rot_y (
    .clk   (clk),
    .en    (en[4:3]),
    .a_i   (v_rx.z),
    .b_i   (v_rx.x),
    .p_i   (v_rx.y),
    .sin_i (sin_y_r),
    .cos_i (cos_y_r),
    .a_o   (v_ry.z),
    .b_o   (v_ry.x),
    .p_o   (v_ry.y)
  );

  // about Z: (x, y)
  vrp_rot u_rot_z (
    .clk   (clk),
    .en    (en[6:5]),
    .a_i   (v_ry.x),
    .b_i   (v_ry.y),
    .p_i   (v_ry.z),
    .sin_i (sin_z_r),
    .cos_i (cos_z_r),
    .a_o   (v_rz.x),
    .b_o   (v_rz.y),
    .p_o   (v_rz.z)
  );

  vrp_iso u_iso (
    .clk    (clk),
    .en     (en[9:7]),
    .iso_en (iso_enable_r),
    .v_i    (v_rz),
    .v_o    (v_iso)
  );

  vrp_scale #(
    .WINDOW_WIDTH  (WINDOW_WIDTH),
    .WINDOW_HEIGHT (WINDOW_HEIGHT)
  ) u_scale (
    .clk      (clk),
    .en       (en[12:10]),
    .v_i      (v_iso),
    .offset_x (offset_x_r),
    .offset_y (offset_y_r),
    .zoom     (zoom_r),
    .out_data (out_data)
  );

endmodule

FILE: rtl/core/vrp_ctrl.sv
// ----------------------------------------------------------------------------
// vrp_ctrl
// Stage valid bits and per-stage load enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module vrp_ctrl
  import vrp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [NUM_STAGES-1:0] en
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] ready;

  assign ready[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || !out_stall;

  genvar g;
  for (g = 0; g < NUM_STAGES - 1; g++) begin : g_ready
    assign ready[g] = !valid_r[g] || ready[g+1];
  end

  always_comb begin
    valid_nxt[0] = ready[0] ? in_valid : valid_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      valid_nxt[i] = ready[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign en        = ready;
  assign in_stall  = !ready[0];
  assign out_valid = valid_r[NUM_STAGES-1];

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> (valid_r == '0))
    else $error("stage valid bits not cleared by reset");

  a_no_invented_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && !in_stall) |=> ($countones(valid_r) <= $past($countones(valid_r))))
    else $error("beat count grew without an input beat");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&valid_r) && out_stall))
    else $error("input stalled while a stage is empty");

endmodule

FILE: rtl/core/vrp_rot.sv
// ----------------------------------------------------------------------------
// vrp_rot
// Plane rotation of (a, b) by a Q1.14 sine/cosine pair; multiply then sum.
// ----------------------------------------------------------------------------
module vrp_rot
  import vrp_pkg::*;
(
  input  logic       clk,
  input  logic [1:0] en,
  input  coord_t     a_i,
  input  coord_t     b_i,
  input  coord_t     p_i,
  input  trig_t      sin_i,
  input  trig_t      cos_i,
  output coord_t     a_o,
  output coord_t     b_o,
  output coord_t     p_o
);

  prod_t  ac_r, bs_r, as_r, bc_r;
  prod_t  ac_nxt, bs_nxt, as_nxt, bc_nxt;
  coord_t p1_r, p2_r;
  coord_t a_r, b_r;
  coord_t a_nxt, b_nxt;

  always_comb begin
    ac_nxt = PROD_W'(a_i) * PROD_W'(cos_i);
    bs_nxt = PROD_W'(b_i) * PROD_W'(sin_i);
    as_nxt = PROD_W'(a_i) * PROD_W'(sin_i);
    bc_nxt = PROD_W'(b_i) * PROD_W'(cos_i);
    a_nxt  = rnd14(RND_W'(ac_r) - RND_W'(bs_r));
    b_nxt  = rnd14(RND_W'(as_r) + RND_W'(bc_r));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ac_r <= ac_nxt;
      bs_r <= bs_nxt;
      as_r <= as_nxt;
      bc_r <= bc_nxt;
      p1_r <= p_i;
    end
    if (en[1]) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      p2_r <= p1_r;
    end
  end

  assign a_o = a_r;
  assign b_o = b_r;
  assign p_o = p2_r;

endmodule

FILE: rtl/core/vrp_iso.sv
// ----------------------------------------------------------------------------
// vrp_iso
// Isometric projection: pre-add, constant multiply, round and bypass select.
// ----------------------------------------------------------------------------
module vrp_iso
  import vrp_pkg::*;
(
  input  logic       clk,
  input  logic [2:0] en,
  input  logic       iso_en,
  input  vec_t       v_i,
  output vec_t       v_o
);

  localparam int ISO_W   = COORD_W + 2;
  localparam int IPROD_W = ISO_W + 16;

  localparam logic signed [15:0] ISO_R2 = 16'sd11585;
  localparam logic signed [15:0] ISO_R6 = 16'sd6689;
  localparam logic signed [15:0] ISO_R3 = 16'sd9459;

  logic signed [ISO_W-1:0]   dxy_r, sxy2z_r, sxyz_r;
  logic signed [ISO_W-1:0]   dxy_nxt, sxy2z_nxt, sxyz_nxt;
  logic signed [IPROD_W-1:0] px_r, py_r, pz_r;
  logic signed [IPROD_W-1:0] px_nxt, py_nxt, pz_nxt;
  vec_t                      v1_r, v2_r, out_r;
  vec_t                      out_nxt;

  always_comb begin
    dxy_nxt   = ISO_W'(v_i.x) - ISO_W'(v_i.y);
    sxy2z_nxt = ISO_W'(v_i.x) + ISO_W'(v_i.y) - (ISO_W'(v_i.z) <<< 1);
    sxyz_nxt  = ISO_W'(v_i.x) + ISO_W'(v_i.y) + ISO_W'(v_i.z);
    px_nxt    = IPROD_W'(dxy_r) * IPROD_W'(ISO_R2);
    py_nxt    = IPROD_W'(sxy2z_r) * IPROD_W'(ISO_R6);
    pz_nxt    = IPROD_W'(sxyz_r) * IPROD_W'(ISO_R3);
    if (iso_en) begin
      out_nxt.x = rnd14(RND_W'(px_r));
      out_nxt.y = rnd14(RND_W'(py_r));
      out_nxt.z = rnd14(RND_W'(pz_r));
    end else begin
      out_nxt = v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dxy_r   <= dxy_nxt;
      sxy2z_r <= sxy2z_nxt;
      sxyz_r  <= sxyz_nxt;
      v1_r    <= v_i;
    end
    if (en[1]) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
      v2_r <= v1_r;
    end
    if (en[2]) begin
      out_r <= out_nxt;
    end
  end

  assign v_o = out_r;

endmodule

FILE: rtl/core/vrp_scale.sv
// ----------------------------------------------------------------------------
// vrp_scale
// Offset, zoom, window centring and saturation; last stage is the output beat.
// ----------------------------------------------------------------------------
module vrp_scale
  import vrp_pkg::*;
#(
  parameter int WINDOW_WIDTH  = 1920,
  parameter int WINDOW_HEIGHT = 1080
) (
  input  logic               clk,
  input  logic [2:0]         en,
  input  vec_t               v_i,
  input  logic signed [15:0] offset_x,
  input  logic signed [15:0] offset_y,
  input  logic [15:0]        zoom,
  output out_item_t          out_data
);

  localparam int OFF_W = COORD_W + 1;
  localparam int ZP_W  = OFF_W + 17;

  localparam logic signed [ZP_W-1:0] CENTER_X = ZP_W'(WINDOW_WIDTH * 128);
  localparam logic signed [ZP_W-1:0] CENTER_Y = ZP_W'(WINDOW_HEIGHT * 128);
  localparam logic signed [ZP_W-1:0] HALF     = ZP_W'(128);

  logic signed [OFF_W-1:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic signed [ZP_W-1:0]  px_r, py_r, px_nxt, py_nxt;
  logic signed [ZP_W-1:0]  sx, sy;
  logic signed [16:0]      zoom_s;
  coord_t                  z1_r, z2_r;
  out_item_t               out_r, out_nxt;

  function automatic logic signed [31:0] sat32(input logic signed [ZP_W-1:0] v);
    if (v[ZP_W-1:31] != {(ZP_W-31){v[31]}}) begin
      return v[ZP_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  always_comb begin
    zoom_s    = signed'({1'b0, zoom});
    ox_nxt    = OFF_W'(v_i.x) + OFF_W'(signed'({offset_x, 8'h00}));
    oy_nxt    = OFF_W'(v_i.y) + OFF_W'(signed'({offset_y, 8'h00}));
    px_nxt    = ZP_W'(ox_r) * ZP_W'(zoom_s);
    py_nxt    = ZP_W'(oy_r) * ZP_W'(zoom_s);
    sx        = ((px_r + HALF) >>> 8) + CENTER_X;
    sy        = ((py_r + HALF) >>> 8) + CENTER_Y;
    out_nxt.out_x     = sat32(sx);
    out_nxt.out_y     = sat32(sy);
    out_nxt.out_depth = 32'(z2_r);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      z1_r <= v_i.z;
    end
    if (en[1]) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      z2_r <= z1_r;
    end
    if (en[2]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
